/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/mbrx_pkg.sv */
`timescale 1ns / 1ps

package mbrx_pkg;

	// Frame tracking phase, one-hot.
	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_FUNC  = 4'b0010,
		PH_COUNT = 4'b0100,
		PH_BODY  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		ST_IGNORED = 3'd0,
		ST_TAKEN   = 3'd1,
		ST_GOOD    = 3'd2,
		ST_BADCRC  = 3'd3,
		ST_BADFUNC = 3'd4,
		ST_TIMEOUT = 3'd5
	} status_t;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] REG_DEV_ADDR  = 2'd0;
	localparam logic [1:0] REG_SHORT_TMO = 2'd1;
	localparam logic [1:0] REG_LONG_TMO  = 2'd2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [8:0] FIXED_FRAME_LEN = 9'd8;
	localparam logic [8:0] MULTI_EXTRA_LEN = 9'd9;
	localparam logic [8:0] COUNT_BYTE_POS  = 9'd7;

	localparam logic [7:0] FC_FIRST_FIXED = 8'd1;
	localparam logic [7:0] FC_LAST_FIXED  = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

	typedef struct packed {
		logic [7:0] dev_addr;
		logic [4:0] short_tmo;
		logic [4:0] long_tmo;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [8:0]  byte_count;
		logic [8:0]  expected_length;
		logic [4:0]  tick_timer;
		logic [15:0] crc;
	} rx_state_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] frame_byte;
		logic [8:0] byte_index;
		logic [8:0] frame_length;
	} result_t;

	// Byte-wise reflected CRC-16 update, eight shift steps.
	function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* rtl/modbus_rtu_frame_receiver_core.sv */
`timescale 1ns / 1ps

// Channel      Direction  Payload
// s_axis_*     in         tuser: opcode (0 byte, 1 tick); tdata: rx_byte
// m_axis_*     out        tuser: status; tdata: frame_byte, byte_index, frame_length
// cfg_*        in         cfg_index: register number; cfg_data: value
//
// One item is accepted per clock unless the output register stalls the input
// register. Each item sits in the input register, where the CRC-16 byte update
// and the frame state update run, and then in the output register until the
// sink takes it. The output register stalls the input register only while both
// are full and m_axis_tready is low. Reset (arst_n low) returns to idle with the
// CRC preset and the configuration at its default values.
module modbus_rtu_frame_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] opcode
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] frame_byte, [16:8] byte_index,
	                                    // [25:17] frame_length, [31:26] zero
	output logic [2:0]  m_axis_tuser,   // [2:0] status
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	mbrx_pkg::cfg_t      cfg_q;
	mbrx_pkg::rx_state_t state_q;
	mbrx_pkg::rx_state_t state_nxt;
	mbrx_pkg::result_t   res_nxt;
	mbrx_pkg::result_t   res_s2;

	logic       valid_s1;
	logic       opcode_s1;
	logic [7:0] rx_byte_s1;
	logic       valid_s2;
	logic       advance;

	// The input register moves on when the output register is empty or is
	// being emptied in this cycle; the frame state is committed at that moment.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	// Configuration registers. Writes to an unknown index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr  <= 8'd1;
			cfg_q.short_tmo <= 5'd5;
			cfg_q.long_tmo  <= 5'd20;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mbrx_pkg::REG_DEV_ADDR:  cfg_q.dev_addr  <= cfg_data;
				mbrx_pkg::REG_SHORT_TMO: cfg_q.short_tmo <= cfg_data[4:0];
				mbrx_pkg::REG_LONG_TMO:  cfg_q.long_tmo  <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// Valid flags and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1                <= 1'b0;
			valid_s2                <= 1'b0;
			state_q.phase           <= mbrx_pkg::PH_IDLE;
			state_q.byte_count      <= 9'd0;
			state_q.expected_length <= 9'd0;
			state_q.tick_timer      <= 5'd0;
			state_q.crc             <= mbrx_pkg::CRC_INIT;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1  <= s_axis_tuser;
			rx_byte_s1 <= s_axis_tdata;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	mbrx_step u_step (
		.cfg     (cfg_q),
		.cur     (state_q),
		.opcode  (opcode_s1),
		.rx_byte (rx_byte_s1),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.status;
	assign m_axis_tdata  = {6'd0, res_s2.frame_length, res_s2.byte_index, res_s2.frame_byte};

endmodule

/* rtl/mbrx_step.sv */
`timescale 1ns / 1ps

// Next-state and result logic for one received byte or poll tick.
module mbrx_step (
	input  mbrx_pkg::cfg_t      cfg,
	input  mbrx_pkg::rx_state_t cur,
	input  logic                opcode,
	input  logic [7:0]          rx_byte,
	output mbrx_pkg::rx_state_t nxt,
	output mbrx_pkg::result_t   res
);

	logic [15:0] crc_base;
	logic [15:0] crc_new;
	logic [8:0]  count_inc;

	// A matching address restarts the CRC, so the base is the initial value in idle.
	assign crc_base  = (cur.phase == mbrx_pkg::PH_IDLE) ? mbrx_pkg::CRC_INIT : cur.crc;
	assign crc_new   = mbrx_pkg::crc_update(crc_base, rx_byte);
	assign count_inc = cur.byte_count + 9'd1;

	always_comb begin
		nxt = cur;
		res = '{status: mbrx_pkg::ST_IGNORED, frame_byte: 8'd0,
			byte_index: 9'd0, frame_length: 9'd0};
		if (opcode == mbrx_pkg::OP_TICK) begin
			if (cur.phase != mbrx_pkg::PH_IDLE) begin
				if (cur.tick_timer <= 5'd1) begin
					nxt.tick_timer = 5'd0;
					nxt.phase      = mbrx_pkg::PH_IDLE;
					res.status     = mbrx_pkg::ST_TIMEOUT;
				end else begin
					nxt.tick_timer = cur.tick_timer - 5'd1;
				end
			end
		end else begin
			unique case (cur.phase)
				mbrx_pkg::PH_IDLE: begin
					if (rx_byte == cfg.dev_addr) begin
						nxt.crc        = crc_new;
						nxt.byte_count = 9'd1;
						nxt.tick_timer = cfg.short_tmo;
						nxt.phase      = mbrx_pkg::PH_FUNC;
						res.status     = mbrx_pkg::ST_TAKEN;
						res.frame_byte = rx_byte;
					end
				end
				mbrx_pkg::PH_FUNC: begin
					res.frame_byte = rx_byte;
					res.byte_index = cur.byte_count;
					if (rx_byte >= mbrx_pkg::FC_FIRST_FIXED &&
						rx_byte <= mbrx_pkg::FC_LAST_FIXED) begin
						nxt.crc             = crc_new;
						nxt.byte_count      = count_inc;
						nxt.expected_length = mbrx_pkg::FIXED_FRAME_LEN;
						nxt.phase           = mbrx_pkg::PH_BODY;
						res.status          = mbrx_pkg::ST_TAKEN;
					end else if (rx_byte == mbrx_pkg::FC_WRITE_COILS ||
						rx_byte == mbrx_pkg::FC_WRITE_REGS) begin
						nxt.crc        = crc_new;
						nxt.byte_count = count_inc;
						nxt.phase      = mbrx_pkg::PH_COUNT;
						res.status     = mbrx_pkg::ST_TAKEN;
					end else begin
						nxt.phase      = mbrx_pkg::PH_IDLE;
						nxt.tick_timer = 5'd0;
						res.status     = mbrx_pkg::ST_BADFUNC;
					end
				end
				mbrx_pkg::PH_COUNT: begin
					nxt.crc        = crc_new;
					nxt.byte_count = count_inc;
					res.status     = mbrx_pkg::ST_TAKEN;
					res.frame_byte = rx_byte;
					res.byte_index = cur.byte_count;
					if (count_inc == mbrx_pkg::COUNT_BYTE_POS) begin
						nxt.expected_length = {1'b0, rx_byte} + mbrx_pkg::MULTI_EXTRA_LEN;
						nxt.tick_timer      = cfg.long_tmo;
						nxt.phase           = mbrx_pkg::PH_BODY;
					end
				end
				mbrx_pkg::PH_BODY: begin
					nxt.crc        = crc_new;
					nxt.byte_count = count_inc;
					res.status     = mbrx_pkg::ST_TAKEN;
					res.frame_byte = rx_byte;
					res.byte_index = cur.byte_count;
					if (count_inc >= cur.expected_length) begin
						nxt.phase        = mbrx_pkg::PH_IDLE;
						nxt.tick_timer   = 5'd0;
						res.frame_length = cur.expected_length;
						res.status       = (crc_new == 16'd0) ? mbrx_pkg::ST_GOOD
							: mbrx_pkg::ST_BADCRC;
					end
				end
				default: begin
					nxt.phase = mbrx_pkg::PH_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/mbrx_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the result stream.
module mbrx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);

	`ASSERT_NEXT(a_stall_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	`ASSERT_IMPLIES(a_ignored_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser == mbrx_pkg::ST_IGNORED, m_axis_tdata == 32'd0)

	`ASSERT_IMPLIES(a_len_on_end, clk, arst_n, m_axis_tvalid && m_axis_tuser != mbrx_pkg::ST_GOOD && m_axis_tuser != mbrx_pkg::ST_BADCRC, m_axis_tdata[25:17] == 9'd0)

	`ASSERT_IMPLIES(a_timeout_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser == mbrx_pkg::ST_TIMEOUT, m_axis_tdata == 32'd0)

endmodule

bind modbus_rtu_frame_receiver_core mbrx_checker u_mbrx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
